>>> sv/plob_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plob_pkg: shared types, constants and helpers of the price-level order book
// Sizes of the book, request opcodes, register indexes, the command and
// status bundles between controller and datapath, and depth saturation.
// ----------------------------------------------------------------------------
package plob_pkg;

  // Book geometry and field widths
  localparam int NUM_LEVELS  = 1024;
  localparam int LVL_W       = $clog2(NUM_LEVELS);
  localparam int DEPTH_BITS  = 32;
  localparam int QTY_W       = 24;
  localparam int IDX_W       = 10;
  localparam int OP_W        = 2;
  localparam int CFG_DEPTH_W = 16;
  localparam int CFG_BB_W    = 10;
  localparam int CFG_W       = (CFG_DEPTH_W > CFG_BB_W) ? CFG_DEPTH_W : CFG_BB_W;
  localparam int CFG_IDX_W   = 1;

  // Widths of intermediate compares
  localparam int SUM_W = ((LVL_W > IDX_W) ? LVL_W : IDX_W) + 1;
  localparam int CMP_W = ((DEPTH_BITS > QTY_W) ? DEPTH_BITS : QTY_W) + 1;

  // Register reset values
  localparam logic [CFG_DEPTH_W-1:0] RST_DEPTH = CFG_DEPTH_W'(50);
  localparam logic [CFG_BB_W-1:0]    RST_BB    = CFG_BB_W'(500);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_DEPTH = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_BB    = CFG_IDX_W'(1);

  typedef enum logic [OP_W-1:0] {
    OP_LIMIT  = OP_W'(0),
    OP_AGGR   = OP_W'(1),
    OP_REINIT = OP_W'(2)
  } op_e;

  typedef logic [LVL_W-1:0]      lvl_t;
  typedef logic [DEPTH_BITS-1:0] depth_t;
  typedef logic [QTY_W-1:0]      qty_t;

  // Controller to datapath
  typedef struct packed {
    logic in_ready;  // request port may accept
    logic take;      // request accepted: latch it, read depth memories
    logic run;       // apply the request and load the result
    logic sweep;     // write one level of the reload sweep
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_valid;
    logic in_reinit;
    logic out_free;
    logic sweep_last;
  } sts_t;

  localparam logic [CMP_W-1:0] DEPTH_MAX_W =
    {{(CMP_W-DEPTH_BITS){1'b0}}, {DEPTH_BITS{1'b1}}};

  // Limit the reload best bid so the best ask stays on the book
  function automatic lvl_t clamp_bb(input logic [CFG_BB_W-1:0] v);
    logic [SUM_W-1:0] w;
    logic [SUM_W-1:0] lim;
    w   = SUM_W'(v);
    lim = SUM_W'(NUM_LEVELS - 2);
    return (w > lim) ? LVL_W'(lim) : LVL_W'(w);
  endfunction

  // Add a quantity to a depth, saturating
  function automatic depth_t sat_add(input depth_t a, input qty_t b);
    logic [CMP_W-1:0] s;
    s = CMP_W'(a) + CMP_W'(b);
    return (s > DEPTH_MAX_W) ? {DEPTH_BITS{1'b1}} : DEPTH_BITS'(s);
  endfunction

  // Convert a quantity to a depth, saturating
  function automatic depth_t sat_q(input qty_t q);
    return (CMP_W'(q) > DEPTH_MAX_W) ? {DEPTH_BITS{1'b1}} : DEPTH_BITS'(q);
  endfunction

endpackage

>>> sv/plob_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plob_req_if: order request channel
// Valid/ready channel carrying one order request.
// ----------------------------------------------------------------------------
interface plob_req_if;
  logic                       valid;
  logic                       ready;
  logic [plob_pkg::OP_W-1:0]  opcode;
  logic                       is_buy;
  logic [plob_pkg::IDX_W-1:0] lvl_off;
  logic [plob_pkg::QTY_W-1:0] quantity;

  modport source (output valid, output opcode, output is_buy, output lvl_off,
                  output quantity, input ready);
  modport sink   (input valid, input opcode, input is_buy, input lvl_off,
                  input quantity, output ready);
endinterface

>>> sv/plob_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plob_rsp_if: order result channel
// Valid/ready channel carrying one result per request.
// ----------------------------------------------------------------------------
interface plob_rsp_if;
  logic                       valid;
  logic                       ready;
  logic                       status;
  logic                       trade_valid;
  logic [plob_pkg::QTY_W-1:0] trade_quantity;
  logic [plob_pkg::IDX_W-1:0] trade_level;
  logic                       trade_is_buy;
  logic [plob_pkg::IDX_W-1:0] best_bid_level;
  logic [plob_pkg::IDX_W-1:0] best_ask_level;

  modport source (output valid, output status, output trade_valid, output trade_quantity,
                  output trade_level, output trade_is_buy, output best_bid_level,
                  output best_ask_level, input ready);
  modport sink   (input valid, input status, input trade_valid, input trade_quantity,
                  input trade_level, input trade_is_buy, input best_bid_level,
                  input best_ask_level, output ready);
endinterface

>>> sv/plob_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plob_ctrl: order book sequencer
// Steps each request through accept and execute, and runs the level sweep
// that reloads both depth memories after reset and on a reinit request.
// ----------------------------------------------------------------------------
module plob_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  plob_pkg::sts_t sts_i,
  output plob_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } state_e;

  state_e state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.sweep = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        cmd_o.in_ready = sts_i.out_free;
        if (sts_i.in_valid && sts_i.out_free) begin
          cmd_o.take = 1'b1;
          state_d    = sts_i.in_reinit ? ST_CLEAR : ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.run = 1'b1;
        state_d   = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Start with a sweep after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> sv/plob_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plob_dp: order book datapath
// Depth memories for both sides, best indices, configuration registers,
// the fill and rest arithmetic and the result register.
// ----------------------------------------------------------------------------
module plob_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  plob_req_if.sink                       req,
  plob_rsp_if.source                     rsp,
  input  logic                           cfg_we_i,
  input  logic [plob_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [plob_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  plob_pkg::cmd_t                 cmd_i,
  output plob_pkg::sts_t                 sts_o
);

  // Configuration registers and reload snapshot
  logic [plob_pkg::CFG_DEPTH_W-1:0] cfg_depth_q, ld_depth_q;
  logic [plob_pkg::CFG_BB_W-1:0]    cfg_bb_q;
  plob_pkg::lvl_t                   ld_bb_q;
  logic                             reinit_pend_q;
  plob_pkg::lvl_t                   clr_q;

  // Book state
  plob_pkg::lvl_t  best_bid_q, best_ask_q;
  plob_pkg::depth_t bid_mem [plob_pkg::NUM_LEVELS];
  plob_pkg::depth_t ask_mem [plob_pkg::NUM_LEVELS];
  plob_pkg::depth_t bid_rd_q, ask_rd_q;

  // Latched request
  plob_pkg::op_e  it_op_q;
  logic           it_buy_q;
  plob_pkg::qty_t it_qty_q;
  plob_pkg::lvl_t addr_q;

  // Result register
  logic                       out_valid_q;
  logic                       o_status_q, o_tv_q, o_tb_q;
  plob_pkg::qty_t             o_tq_q;
  logic [plob_pkg::IDX_W-1:0] o_tl_q, o_bid_q, o_ask_q;

  // Request decode
  plob_pkg::op_e             in_op;
  logic [plob_pkg::SUM_W-1:0] off_w, bid_w, ask_w, sum_w, max_w;
  plob_pkg::lvl_t            rd_addr;
  plob_pkg::lvl_t            ld_bb_new;

  assign in_op     = plob_pkg::op_e'(req.opcode);
  assign ld_bb_new = plob_pkg::clamp_bb(cfg_bb_q);

  // Pick the level that the request reads
  always_comb begin
    off_w = plob_pkg::SUM_W'(req.lvl_off);
    bid_w = plob_pkg::SUM_W'(best_bid_q);
    ask_w = plob_pkg::SUM_W'(best_ask_q);
    max_w = plob_pkg::SUM_W'(plob_pkg::NUM_LEVELS - 1);
    sum_w = ask_w + off_w;
    case (in_op)
      plob_pkg::OP_LIMIT: begin
        if (req.is_buy) begin
          rd_addr = (off_w > bid_w) ? '0 : plob_pkg::LVL_W'(bid_w - off_w);
        end else begin
          rd_addr = (sum_w > max_w) ? plob_pkg::LVL_W'(max_w) : plob_pkg::LVL_W'(sum_w);
        end
      end
      plob_pkg::OP_AGGR: rd_addr = req.is_buy ? best_ask_q : best_bid_q;
      default:           rd_addr = best_bid_q;
    endcase
  end

  // Execute arithmetic
  logic                       spread2, edge_ok, ok;
  plob_pkg::depth_t           opp, left;
  plob_pkg::qty_t             fill, rem;
  plob_pkg::lvl_t             bid_inc, bid_dec, ask_inc, ask_dec;
  plob_pkg::lvl_t             nb, na;
  logic                       bid_we, ask_we;
  plob_pkg::lvl_t             bid_wa, ask_wa;
  plob_pkg::depth_t           bid_wd, ask_wd, ld_ext;
  logic                       x_status, x_tv, x_tb;
  plob_pkg::qty_t             x_tq;
  logic [plob_pkg::IDX_W-1:0] x_tl;

  assign spread2 = (best_ask_q - best_bid_q) == plob_pkg::LVL_W'(2);
  assign opp     = it_buy_q ? ask_rd_q : bid_rd_q;
  assign fill    = (plob_pkg::CMP_W'(it_qty_q) < plob_pkg::CMP_W'(opp)) ?
                   it_qty_q : plob_pkg::QTY_W'(opp);
  assign rem     = it_qty_q - fill;
  assign left    = opp - plob_pkg::DEPTH_BITS'(fill);
  assign edge_ok = it_buy_q ? (best_ask_q != plob_pkg::LVL_W'(plob_pkg::NUM_LEVELS - 1))
                            : (best_bid_q != '0);
  assign ok      = ((rem != '0) || (left == '0)) ? edge_ok : 1'b1;
  assign bid_inc = best_bid_q + plob_pkg::LVL_W'(1);
  assign bid_dec = best_bid_q - plob_pkg::LVL_W'(1);
  assign ask_inc = best_ask_q + plob_pkg::LVL_W'(1);
  assign ask_dec = best_ask_q - plob_pkg::LVL_W'(1);
  assign ld_ext  = plob_pkg::DEPTH_BITS'(ld_depth_q);

  // Apply the request, or write one sweep level
  always_comb begin
    nb       = best_bid_q;
    na       = best_ask_q;
    bid_we   = 1'b0;
    ask_we   = 1'b0;
    bid_wa   = addr_q;
    ask_wa   = addr_q;
    bid_wd   = '0;
    ask_wd   = '0;
    x_status = 1'b0;
    x_tv     = 1'b0;
    x_tq     = '0;
    x_tl     = '0;
    x_tb     = 1'b0;
    if (cmd_i.run) begin
      case (it_op_q)
        plob_pkg::OP_LIMIT: begin
          if (it_buy_q) begin
            bid_we = 1'b1;
            bid_wd = plob_pkg::sat_add(bid_rd_q, it_qty_q);
          end else begin
            ask_we = 1'b1;
            ask_wd = plob_pkg::sat_add(ask_rd_q, it_qty_q);
          end
        end
        plob_pkg::OP_AGGR: begin
          if (spread2) begin
            // improve the price by one level
            if (it_buy_q) begin
              nb     = bid_inc;
              bid_we = 1'b1;
              bid_wa = bid_inc;
              bid_wd = plob_pkg::sat_q(it_qty_q);
            end else begin
              na     = ask_dec;
              ask_we = 1'b1;
              ask_wa = ask_dec;
              ask_wd = plob_pkg::sat_q(it_qty_q);
            end
          end else if (!ok) begin
            x_status = 1'b1;
          end else begin
            // drain the opposite best level
            if (it_buy_q) begin
              ask_we = 1'b1;
              ask_wd = left;
            end else begin
              bid_we = 1'b1;
              bid_wd = left;
            end
            if (fill != '0) begin
              x_tv = 1'b1;
              x_tq = fill;
              x_tl = plob_pkg::IDX_W'(addr_q);
              x_tb = it_buy_q;
            end
            // rest the remainder one level further, or step past an empty level
            if (rem != '0) begin
              if (it_buy_q) begin
                nb     = bid_inc;
                na     = ask_inc;
                bid_wa = bid_inc;
                bid_we = 1'b1;
                bid_wd = plob_pkg::sat_q(rem);
              end else begin
                na     = ask_dec;
                nb     = bid_dec;
                ask_wa = ask_dec;
                ask_we = 1'b1;
                ask_wd = plob_pkg::sat_q(rem);
              end
            end else if (left == '0) begin
              if (it_buy_q) begin
                na = ask_inc;
              end else begin
                nb = bid_dec;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end else if (cmd_i.sweep) begin
      bid_we = 1'b1;
      ask_we = 1'b1;
      bid_wa = clr_q;
      ask_wa = clr_q;
      bid_wd = (clr_q <= ld_bb_q) ? ld_ext : '0;
      ask_wd = (clr_q <= ld_bb_q) ? '0 : ld_ext;
    end
  end

  // Depth memories
  always_ff @(posedge clk_i) begin
    if (bid_we) begin
      bid_mem[bid_wa] <= bid_wd;
    end
    if (cmd_i.take) begin
      bid_rd_q <= bid_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ask_we) begin
      ask_mem[ask_wa] <= ask_wd;
    end
    if (cmd_i.take) begin
      ask_rd_q <= ask_mem[rd_addr];
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_depth_q <= plob_pkg::RST_DEPTH;
      cfg_bb_q    <= plob_pkg::RST_BB;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        plob_pkg::CFG_INIT_DEPTH: cfg_depth_q <= cfg_wdata_i[plob_pkg::CFG_DEPTH_W-1:0];
        plob_pkg::CFG_INIT_BB:    cfg_bb_q    <= cfg_wdata_i[plob_pkg::CFG_BB_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Best indices, reload snapshot and sweep counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_bid_q    <= plob_pkg::clamp_bb(plob_pkg::RST_BB);
      best_ask_q    <= plob_pkg::clamp_bb(plob_pkg::RST_BB) + plob_pkg::LVL_W'(1);
      ld_depth_q    <= plob_pkg::RST_DEPTH;
      ld_bb_q       <= plob_pkg::clamp_bb(plob_pkg::RST_BB);
      reinit_pend_q <= 1'b0;
      clr_q         <= '0;
    end else begin
      if (cmd_i.take && (in_op == plob_pkg::OP_REINIT)) begin
        ld_depth_q    <= cfg_depth_q;
        ld_bb_q       <= ld_bb_new;
        best_bid_q    <= ld_bb_new;
        best_ask_q    <= ld_bb_new + plob_pkg::LVL_W'(1);
        reinit_pend_q <= 1'b1;
      end else if (cmd_i.run) begin
        best_bid_q <= nb;
        best_ask_q <= na;
      end
      if (cmd_i.sweep) begin
        clr_q <= clr_q + plob_pkg::LVL_W'(1);
        if (sts_o.sweep_last) begin
          reinit_pend_q <= 1'b0;
        end
      end
    end
  end

  // Latch the request
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      it_op_q  <= in_op;
      it_buy_q <= req.is_buy;
      it_qty_q <= req.quantity;
      addr_q   <= rd_addr;
    end
  end

  // Result register
  logic out_load, out_reload;
  assign out_reload = cmd_i.sweep && sts_o.sweep_last && reinit_pend_q;
  assign out_load   = cmd_i.run || out_reload;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (rsp.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.run) begin
      o_status_q <= x_status;
      o_tv_q     <= x_tv;
      o_tq_q     <= x_tq;
      o_tl_q     <= x_tl;
      o_tb_q     <= x_tb;
      o_bid_q    <= plob_pkg::IDX_W'(nb);
      o_ask_q    <= plob_pkg::IDX_W'(na);
    end else if (out_reload) begin
      o_status_q <= 1'b0;
      o_tv_q     <= 1'b0;
      o_tq_q     <= '0;
      o_tl_q     <= '0;
      o_tb_q     <= 1'b0;
      o_bid_q    <= plob_pkg::IDX_W'(best_bid_q);
      o_ask_q    <= plob_pkg::IDX_W'(best_ask_q);
    end
  end

  // Ports and status
  assign req.ready          = cmd_i.in_ready;
  assign rsp.valid          = out_valid_q;
  assign rsp.status         = o_status_q;
  assign rsp.trade_valid    = o_tv_q;
  assign rsp.trade_quantity = o_tq_q;
  assign rsp.trade_level    = o_tl_q;
  assign rsp.trade_is_buy   = o_tb_q;
  assign rsp.best_bid_level = o_bid_q;
  assign rsp.best_ask_level = o_ask_q;

  assign sts_o.in_valid   = req.valid;
  assign sts_o.in_reinit  = (in_op == plob_pkg::OP_REINIT);
  assign sts_o.out_free   = !out_valid_q || rsp.ready;
  assign sts_o.sweep_last = (clr_q == plob_pkg::LVL_W'(plob_pkg::NUM_LEVELS - 1));

endmodule

>>> sv/price_level_order_book.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// price_level_order_book: price-level limit order book
// Keeps bid and ask depth per level with best indices; handles limit,
// aggressive and reinit requests, one result per request.
// ----------------------------------------------------------------------------
// A limit or aggressive request reads both depth memories into registers in
// its accept cycle; the next cycle updates at most one depth entry per side
// and the best indices and loads the result register. No new request is
// accepted before the previous one has executed, and a result left waiting
// on the output holds off the next request until it is taken. A reinit
// request reloads both depth memories one level per cycle; its result
// appears at the end of that sweep. After reset the same sweep runs with the
// reset register values before the first request is accepted; register
// writes are taken throughout.
module price_level_order_book (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  plob_req_if.sink                       req_i,
  plob_rsp_if.source                     rsp_o,
  input  logic                           cfg_we_i,
  input  logic [plob_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [plob_pkg::CFG_W-1:0]     cfg_wdata_i
);

  plob_pkg::cmd_t cmd;
  plob_pkg::sts_t sts;

  // Sequencer
  plob_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // Book storage and arithmetic
  plob_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req         (req_i),
    .rsp         (rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule
